FILE: rtl/tslu_pkg.sv
// Shared types and constants for the Thumb shift/logic execute unit.
// No dependencies; every other file in rtl/ imports this package.
package tslu_pkg;

    localparam int DATA_W = 32;
    localparam int AMT_W  = 8;
    localparam int CMD_W  = 4;
    localparam int SH_W   = 5;    // in-range shift distance, 0..31

    typedef enum logic [CMD_W-1:0] {
        CMD_LSL   = 4'd0,
        CMD_LSR   = 4'd1,
        CMD_ASR   = 4'd2,
        CMD_ROR   = 4'd3,
        CMD_BIC   = 4'd4,
        CMD_MVN   = 4'd5,
        CMD_RSB   = 4'd6,
        CMD_NOP   = 4'd7,
        CMD_REV   = 4'd8,
        CMD_REV16 = 4'd9,
        CMD_REVSH = 4'd10
    } cmd_t;

    // one instruction beat as held in the input register
    typedef struct packed {
        logic [CMD_W-1:0]  cmd;
        logic [DATA_W-1:0] dest_old;
        logic [DATA_W-1:0] source_value;
        logic [AMT_W-1:0]  shift_amount;
        logic              carry_in;
        logic [DATA_W-1:0] pc_in;
    } instr_t;

    // one result beat as held in the result register
    typedef struct packed {
        logic [DATA_W-1:0] result_value;
        logic              flag_neg;
        logic              flag_zero;
        logic              flag_carry;
        logic              flags_updated;
        logic [DATA_W-1:0] pc_out;
    } result_t;

endpackage

FILE: rtl/tslu_in_if.sv
// Instruction channel: valid/ready handshake plus the instruction fields.
// Depends on tslu_pkg for field widths.
interface tslu_in_if
    import tslu_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [CMD_W-1:0]  cmd;
    logic [DATA_W-1:0] dest_old;
    logic [DATA_W-1:0] source_value;
    logic [AMT_W-1:0]  shift_amount;
    logic              carry_in;
    logic [DATA_W-1:0] pc_in;

    modport source (
        output valid, cmd, dest_old, source_value, shift_amount, carry_in, pc_in,
        input  ready
    );

    modport sink (
        input  valid, cmd, dest_old, source_value, shift_amount, carry_in, pc_in,
        output ready
    );
endinterface

FILE: rtl/tslu_out_if.sv
// Result channel: valid/ready handshake plus the result fields.
// Depends on tslu_pkg for field widths.
interface tslu_out_if
    import tslu_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [DATA_W-1:0] result_value;
    logic              flag_neg;
    logic              flag_zero;
    logic              flag_carry;
    logic              flags_updated;
    logic [DATA_W-1:0] pc_out;

    modport source (
        output valid, result_value, flag_neg, flag_zero, flag_carry, flags_updated,
               pc_out,
        input  ready
    );

    modport sink (
        input  valid, result_value, flag_neg, flag_zero, flag_carry, flags_updated,
               pc_out,
        output ready
    );
endinterface

FILE: rtl/thumb_shift_logic_unit.sv
// Thumb shift / logic / byte-reverse execute unit.
// A result beat becomes valid once its instruction has moved from the input register
// into the result register.
// Throughput: one instruction per cycle; the only limit is the result stall.
// Input register -> shifter/logic -> result register; ready chains back from
// the result side. Reset (rst_n low, async) empties both stages.
module thumb_shift_logic_unit
    import tslu_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    tslu_in_if.sink     instr,
    tslu_out_if.source  res
);

    logic    s1_valid_reg;
    instr_t  s1_reg;
    logic    out_valid_reg;
    result_t out_reg;

    logic    s1_ready;
    logic    s2_ready;
    result_t calc;

    assign s2_ready    = !out_valid_reg || res.ready;
    assign s1_ready    = !s1_valid_reg || s2_ready;
    assign instr.ready = s1_ready;

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (s1_ready)
        begin
            s1_valid_reg <= instr.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_ready && instr.valid)
        begin
            s1_reg.cmd          <= instr.cmd;
            s1_reg.dest_old     <= instr.dest_old;
            s1_reg.source_value <= instr.source_value;
            s1_reg.shift_amount <= instr.shift_amount;
            s1_reg.carry_in     <= instr.carry_in;
            s1_reg.pc_in        <= instr.pc_in;
        end
    end

    // execute
    logic [DATA_W-1:0] src;
    logic [DATA_W-1:0] dold;
    logic [AMT_W-1:0]  amt;
    logic [SH_W-1:0]   sh;
    logic              amt_zero;
    logic              amt_big;       // 32 or more
    logic              amt_32;
    logic              sign;
    logic [DATA_W:0]   lsl_w;         // carry in the top bit
    logic [DATA_W:0]   lsr_w;         // carry in the bottom bit
    logic [DATA_W:0]   asr_w;
    logic [2*DATA_W-1:0] ror_w;
    logic [DATA_W-1:0] rev_v;
    logic [DATA_W-1:0] res_v;
    logic              c_v;
    logic              upd_v;

    always_comb
    begin
        src      = s1_reg.source_value;
        dold     = s1_reg.dest_old;
        amt      = s1_reg.shift_amount;
        sh       = amt[SH_W-1:0];
        amt_zero = (amt == '0);
        amt_big  = (amt[AMT_W-1:SH_W] != '0);
        amt_32   = (amt == AMT_W'(DATA_W));
        sign     = src[DATA_W-1];
        lsl_w    = {1'b0, src} << sh;
        lsr_w    = {src, 1'b0} >> sh;
        asr_w    = $unsigned($signed({src, 1'b0}) >>> sh);
        ror_w    = {src, src} >> sh;
        rev_v    = {dold[7:0], dold[15:8], dold[23:16], dold[31:24]};

        res_v = dold;
        c_v   = s1_reg.carry_in;
        upd_v = 1'b1;

        unique case (cmd_t'(s1_reg.cmd))
            CMD_LSL:
            begin
                if (amt_zero)
                    res_v = src;
                else if (!amt_big)
                begin
                    res_v = lsl_w[DATA_W-1:0];
                    c_v   = lsl_w[DATA_W];
                end
                else
                begin
                    res_v = '0;
                    c_v   = amt_32 && src[0];
                end
            end
            CMD_LSR:
            begin
                if (amt_zero)
                    res_v = src;
                else if (!amt_big)
                begin
                    res_v = lsr_w[DATA_W:1];
                    c_v   = lsr_w[0];
                end
                else
                begin
                    res_v = '0;
                    c_v   = amt_32 && sign;
                end
            end
            CMD_ASR:
            begin
                if (amt_zero)
                    res_v = src;
                else if (!amt_big)
                begin
                    res_v = asr_w[DATA_W:1];
                    c_v   = asr_w[0];
                end
                else
                begin
                    res_v = {DATA_W{sign}};
                    c_v   = sign;
                end
            end
            CMD_ROR:
            begin
                // multiples of 32 pass the value but still update C
                res_v = ror_w[DATA_W-1:0];
                if (!amt_zero)
                    c_v = ror_w[DATA_W-1];
            end
            CMD_BIC:
            begin
                res_v = dold & ~src;
                c_v   = 1'b0;
            end
            CMD_MVN:
            begin
                res_v = ~src;
                c_v   = 1'b0;
            end
            CMD_RSB:
            begin
                res_v = '0 - src;
            end
            CMD_REV:
            begin
                res_v = rev_v;
                upd_v = 1'b0;
            end
            CMD_REV16:
            begin
                res_v = {dold[23:16], dold[31:24], dold[7:0], dold[15:8]};
                upd_v = 1'b0;
            end
            CMD_REVSH:
            begin
                res_v = {{(DATA_W-16){dold[7]}}, dold[7:0], dold[15:8]};
                upd_v = 1'b0;
            end
            default:
            begin
                // NOP and unused codes
                res_v = dold;
                upd_v = 1'b0;
            end
        endcase

        calc.result_value  = res_v;
        calc.flag_neg      = res_v[DATA_W-1];
        calc.flag_zero     = (res_v == '0);
        calc.flag_carry    = c_v;
        calc.flags_updated = upd_v;
        calc.pc_out        = s1_reg.pc_in + DATA_W'(1);
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (s2_ready)
        begin
            out_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s2_ready && s1_valid_reg)
        begin
            out_reg <= calc;
        end
    end

    assign res.valid         = out_valid_reg;
    assign res.result_value  = out_reg.result_value;
    assign res.flag_neg      = out_reg.flag_neg;
    assign res.flag_zero     = out_reg.flag_zero;
    assign res.flag_carry    = out_reg.flag_carry;
    assign res.flags_updated = out_reg.flags_updated;
    assign res.pc_out        = out_reg.pc_out;

    // a stalled instruction must stay put in the input register
    a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && !s2_ready) |=> (s1_valid_reg && $stable(s1_reg)))
        else $error("input stage lost or changed a stalled beat");

    // an accepted beat always lands in the input register
    a_s1_load: assert property (@(posedge clk) disable iff (!rst_n)
        (instr.valid && instr.ready) |=> s1_valid_reg)
        else $error("accepted beat not captured");

    // a new result only appears when the input stage held a beat
    a_out_src: assert property (@(posedge clk) disable iff (!rst_n)
        (!out_valid_reg && !s1_valid_reg) |=> !out_valid_reg)
        else $error("result beat with no instruction behind it");

    // pc_out tracks the instruction that moved into the result register
    a_pc: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && s2_ready) |=>
            (res.pc_out == DATA_W'($past(s1_reg.pc_in) + DATA_W'(1))))
        else $error("pc_out mismatch");

endmodule

FILE: tb/sv/tb_thumb_shift_logic_unit.sv
`timescale 1ns / 100ps
// Self-checking bench for thumb_shift_logic_unit: directed corner instructions,
// then random ones, each result compared field by field against a local predictor.
// Depends on rtl/tslu_pkg.sv, rtl/tslu_in_if.sv, rtl/tslu_out_if.sv and the unit.
module tb_thumb_shift_logic_unit;
    import tslu_pkg::*;

    localparam int RANDOM_ITEMS = 950;
    localparam int TAIL_ITEMS   = 150;   // no idling on either side in the last stretch
    localparam int STALL_LIMIT  = 500;   // cycles without any beat before giving up
    localparam int PRINT_LIMIT  = 50;
    localparam logic [CMD_W-1:0] CMD_SPARE_FIRST = 4'd11;
    localparam logic [CMD_W-1:0] CMD_SPARE_LAST  = 4'd15;

    typedef struct {
        instr_t ins;
        bit     drain_first;   // hold this one back until the unit is empty
    } pending_instr_t;

    logic clk = 1'b0;
    logic rst_n;

    tslu_in_if  instr_bus ();
    tslu_out_if res_bus ();

    thumb_shift_logic_unit u_top (
        .clk   (clk),
        .rst_n (rst_n),
        .instr (instr_bus),
        .res   (res_bus)
    );

    always #1 clk = ~clk;

    pending_instr_t pending_instr_q[$];
    result_t        expected_res_q[$];

    int          total_items;
    int          instr_beats = 0;
    int          res_beats   = 0;
    int          err_count   = 0;
    int          idle_cycles = 0;
    int          src_gap     = 0;
    int          snk_gap     = 0;
    int          drain_count = 0;
    bit          in_taken    = 1'b0;
    bit [15:0]   cmd_seen    = '0;

    // New destination value, flags and next PC for one instruction.
    function automatic result_t predict_exec(instr_t ins);
        result_t     r;
        logic [31:0] src;
        logic [31:0] dold;
        logic [31:0] val;
        logic        c;
        logic        upd;
        logic        sgn;
        int unsigned amt;
        int unsigned rot;
        src  = ins.source_value;
        dold = ins.dest_old;
        amt  = ins.shift_amount;
        sgn  = src[31];
        val  = dold;
        c    = ins.carry_in;
        upd  = 1'b1;
        case (ins.cmd)
            CMD_LSL: begin
                if (amt == 0)
                    val = src;
                else if (amt < 32)
                begin
                    val = src << amt;
                    c   = src[32 - amt];
                end
                else if (amt == 32)
                begin
                    val = '0;
                    c   = src[0];
                end
                else
                begin
                    val = '0;
                    c   = 1'b0;
                end
            end
            CMD_LSR: begin
                if (amt == 0)
                    val = src;
                else if (amt < 32)
                begin
                    val = src >> amt;
                    c   = src[amt - 1];
                end
                else if (amt == 32)
                begin
                    val = '0;
                    c   = sgn;
                end
                else
                begin
                    val = '0;
                    c   = 1'b0;
                end
            end
            CMD_ASR: begin
                if (amt == 0)
                    val = src;
                else if (amt < 32)
                begin
                    val = $signed(src) >>> amt;
                    c   = src[amt - 1];
                end
                else
                begin
                    val = {32{sgn}};
                    c   = sgn;
                end
            end
            CMD_ROR: begin
                if (amt == 0)
                    val = src;
                else
                begin
                    rot = amt % 32;
                    val = (rot == 0) ? src : ((src >> rot) | (src << (32 - rot)));
                    c   = val[31];
                end
            end
            CMD_BIC: begin
                val = dold & ~src;
                c   = 1'b0;
            end
            CMD_MVN: begin
                val = ~src;
                c   = 1'b0;
            end
            CMD_RSB:   val = 32'd0 - src;   // carry kept
            CMD_REV: begin
                val = {dold[7:0], dold[15:8], dold[23:16], dold[31:24]};
                upd = 1'b0;
            end
            CMD_REV16: begin
                val = {dold[23:16], dold[31:24], dold[7:0], dold[15:8]};
                upd = 1'b0;
            end
            CMD_REVSH: begin
                val = {{16{dold[7]}}, dold[7:0], dold[15:8]};
                upd = 1'b0;
            end
            default:   upd = 1'b0;          // NOP and the spare codes
        endcase
        r.result_value  = val;
        r.flag_neg      = val[31];
        r.flag_zero     = (val == '0);
        r.flag_carry    = c;
        r.flags_updated = upd;
        r.pc_out        = ins.pc_in + 32'd1;
        return r;
    endfunction

    function automatic logic [31:0] rand_word();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return '1;
            2:       return 32'h8000_0000 | 32'($urandom_range(0, 255));
            3:       return 32'd1 << $urandom_range(0, 31);
            default: return $urandom;
        endcase
    endfunction

    task automatic queue_instr(input logic [CMD_W-1:0] cmd, input logic [31:0] dold,
                               input logic [31:0] src, input logic [7:0] amt,
                               input logic cin, input logic [31:0] pc,
                               input bit drain_first);
        pending_instr_t p;
        p.ins.cmd          = cmd;
        p.ins.dest_old     = dold;
        p.ins.source_value = src;
        p.ins.shift_amount = amt;
        p.ins.carry_in     = cin;
        p.ins.pc_in        = pc;
        p.drain_first      = drain_first;
        pending_instr_q.push_back(p);
    endtask

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        err_count++;
        if (err_count <= PRINT_LIMIT)
            $display("MISMATCH result beat %0d %s: got %h expected %h",
                     res_beats, what, got, want);
    endtask

    // Instruction driver: new beat only once the previous one went through.
    always @(negedge clk)
    begin
        pending_instr_t nxt;
        logic           drive_v;
        bit             idle_ok;
        if (rst_n)
        begin
            drive_v = instr_bus.valid;
            idle_ok = (pending_instr_q.size() > TAIL_ITEMS) && ((instr_beats / 128) % 4 != 3);
            if (!instr_bus.valid || in_taken)
            begin
                drive_v = 1'b0;
                if (src_gap != 0)
                    src_gap--;
                else if (pending_instr_q.size() != 0 &&
                         !(pending_instr_q[0].drain_first && expected_res_q.size() != 0))
                begin
                    nxt = pending_instr_q.pop_front();
                    if (nxt.drain_first)
                        drain_count++;
                    instr_bus.cmd          <= nxt.ins.cmd;
                    instr_bus.dest_old     <= nxt.ins.dest_old;
                    instr_bus.source_value <= nxt.ins.source_value;
                    instr_bus.shift_amount <= nxt.ins.shift_amount;
                    instr_bus.carry_in     <= nxt.ins.carry_in;
                    instr_bus.pc_in        <= nxt.ins.pc_in;
                    drive_v = 1'b1;
                    if (idle_ok && $urandom_range(0, 7) == 0)
                        src_gap = $urandom_range(1, 9);
                end
            end
            instr_bus.valid <= drive_v;
        end
    end

    // Result side back-pressure in random bursts.
    always @(negedge clk)
    begin
        bit idle_ok;
        if (rst_n)
        begin
            idle_ok = (total_items - res_beats > TAIL_ITEMS) && ((res_beats / 128) % 4 != 1);
            if (snk_gap != 0)
            begin
                snk_gap--;
                res_bus.ready <= 1'b0;
            end
            else if (idle_ok && $urandom_range(0, 7) == 0)
            begin
                snk_gap = $urandom_range(0, 8);
                res_bus.ready <= 1'b0;
            end
            else
                res_bus.ready <= 1'b1;
        end
    end

    // Monitor: predict on each instruction beat, check each result beat.
    always @(posedge clk)
    begin
        instr_t  got_in;
        result_t want;
        bit      in_fire;
        bit      out_fire;
        in_fire  = rst_n && instr_bus.valid && instr_bus.ready;
        out_fire = rst_n && res_bus.valid && res_bus.ready;
        in_taken <= in_fire;
        if (in_fire)
        begin
            got_in.cmd          = instr_bus.cmd;
            got_in.dest_old     = instr_bus.dest_old;
            got_in.source_value = instr_bus.source_value;
            got_in.shift_amount = instr_bus.shift_amount;
            got_in.carry_in     = instr_bus.carry_in;
            got_in.pc_in        = instr_bus.pc_in;
            expected_res_q.push_back(predict_exec(got_in));
            cmd_seen[got_in.cmd] = 1'b1;
            instr_beats++;
        end
        if (out_fire)
        begin
            if (expected_res_q.size() == 0)
                report_mismatch("beat with nothing pending", res_bus.result_value, '0);
            else
            begin
                want = expected_res_q.pop_front();
                if (res_bus.result_value !== want.result_value)
                    report_mismatch("result_value", res_bus.result_value, want.result_value);
                if (res_bus.flag_neg !== want.flag_neg)
                    report_mismatch("flag_neg", 32'(res_bus.flag_neg), 32'(want.flag_neg));
                if (res_bus.flag_zero !== want.flag_zero)
                    report_mismatch("flag_zero", 32'(res_bus.flag_zero), 32'(want.flag_zero));
                if (res_bus.flag_carry !== want.flag_carry)
                    report_mismatch("flag_carry", 32'(res_bus.flag_carry),
                                    32'(want.flag_carry));
                if (res_bus.flags_updated !== want.flags_updated)
                    report_mismatch("flags_updated", 32'(res_bus.flags_updated),
                                    32'(want.flags_updated));
                if (res_bus.pc_out !== want.pc_out)
                    report_mismatch("pc_out", res_bus.pc_out, want.pc_out);
            end
            res_beats++;
        end
        if (rst_n)
        begin
            if (in_fire || out_fire)
                idle_cycles = 0;
            else
            begin
                idle_cycles++;
                if (idle_cycles >= STALL_LIMIT)
                begin
                    $display("watchdog: no beat for %0d cycles, %0d results outstanding",
                             idle_cycles, expected_res_q.size());
                    $display("CHECKS FAILED");
                    $finish;
                end
            end
        end
    end

    initial
    begin
        logic [CMD_W-1:0] cmd;
        logic [7:0]       amt;
        rst_n                  = 1'b0;
        instr_bus.valid        = 1'b0;
        instr_bus.cmd          = '0;
        instr_bus.dest_old     = '0;
        instr_bus.source_value = '0;
        instr_bus.shift_amount = '0;
        instr_bus.carry_in     = 1'b0;
        instr_bus.pc_in        = '0;
        res_bus.ready          = 1'b0;

        // shift corners: zero keeps carry, 32 and above fill, ROR by multiples of 32
        queue_instr(CMD_LSL, 32'h0, 32'h8000_0001, 8'd0,   1'b1, 32'h0000_0000, 1'b0);
        queue_instr(CMD_LSL, 32'h0, 32'h8000_0001, 8'd1,   1'b0, 32'h0000_0100, 1'b0);
        queue_instr(CMD_LSL, 32'h0, 32'h0000_0003, 8'd31,  1'b0, 32'h0000_0200, 1'b0);
        queue_instr(CMD_LSL, 32'h0, 32'h0000_0001, 8'd32,  1'b0, 32'h0000_0300, 1'b0);
        queue_instr(CMD_LSL, 32'h0, 32'hFFFF_FFFF, 8'd33,  1'b1, 32'h0000_0400, 1'b0);
        queue_instr(CMD_LSR, 32'h0, 32'hFFFF_FFFF, 8'd0,   1'b0, 32'h0000_0500, 1'b0);
        queue_instr(CMD_LSR, 32'h0, 32'h8000_0000, 8'd32,  1'b0, 32'h0000_0600, 1'b0);
        queue_instr(CMD_LSR, 32'h0, 32'hFFFF_FFFF, 8'd255, 1'b1, 32'h0000_0700, 1'b0);
        queue_instr(CMD_ASR, 32'h0, 32'h8000_0000, 8'd31,  1'b0, 32'h0000_0800, 1'b0);
        queue_instr(CMD_ASR, 32'h0, 32'h8000_0000, 8'd32,  1'b0, 32'h0000_0900, 1'b0);
        queue_instr(CMD_ASR, 32'h0, 32'h7FFF_FFFF, 8'd200, 1'b1, 32'h0000_0A00, 1'b0);
        queue_instr(CMD_ROR, 32'h0, 32'h1234_5678, 8'd0,   1'b1, 32'h0000_0B00, 1'b0);
        queue_instr(CMD_ROR, 32'h0, 32'h8000_0001, 8'd32,  1'b0, 32'h0000_0C00, 1'b0);
        queue_instr(CMD_ROR, 32'h0, 32'h7FFF_FFFE, 8'd64,  1'b1, 32'h0000_0D00, 1'b0);
        queue_instr(CMD_ROR, 32'h0, 32'h0000_0001, 8'd33,  1'b0, 32'h0000_0E00, 1'b0);
        // logic, negate, byte reverses, NOP with PC wrap, spare codes
        queue_instr(CMD_BIC, 32'hFFFF_FFFF, 32'h0F0F_0F0F, 8'd7, 1'b1, 32'h1000_0000, 1'b0);
        queue_instr(CMD_MVN, 32'h0, 32'h0000_0000, 8'd0,   1'b1, 32'h2000_0000, 1'b0);
        queue_instr(CMD_MVN, 32'h0, 32'hFFFF_FFFF, 8'd0,   1'b1, 32'h3000_0000, 1'b0);
        queue_instr(CMD_RSB, 32'h0, 32'h0000_0000, 8'd0,   1'b1, 32'h4000_0000, 1'b0);
        queue_instr(CMD_RSB, 32'h0, 32'h8000_0000, 8'd0,   1'b0, 32'h5000_0000, 1'b0);
        queue_instr(CMD_NOP, 32'h0, 32'hFFFF_FFFF, 8'd255, 1'b1, 32'hFFFF_FFFF, 1'b0);
        queue_instr(CMD_REV,   32'h1234_5678, 32'h0, 8'd0, 1'b1, 32'h6000_0000, 1'b0);
        queue_instr(CMD_REV16, 32'hA1B2_C3D4, 32'h0, 8'd0, 1'b0, 32'h7000_0000, 1'b0);
        queue_instr(CMD_REVSH, 32'h0000_1280, 32'h0, 8'd0, 1'b1, 32'h8000_0000, 1'b0);
        queue_instr(CMD_REVSH, 32'hFFFF_7F01, 32'h0, 8'd0, 1'b0, 32'h9000_0000, 1'b0);
        queue_instr(CMD_SPARE_FIRST, 32'hDEAD_BEEF, 32'h0, 8'd3, 1'b1, 32'hA000_0000, 1'b0);
        queue_instr(CMD_SPARE_LAST,  32'h0000_0000, 32'h1, 8'd9, 1'b0, 32'hB000_0000, 1'b0);

        for (int k = 0; k < RANDOM_ITEMS; k++)
        begin
            if ($urandom_range(0, 9) == 0)
                cmd = 4'($urandom_range(0, 15));
            else
                cmd = 4'($urandom_range(int'(CMD_LSL), int'(CMD_REVSH)));
            case ($urandom_range(0, 3))
                0, 1:    amt = 8'($urandom_range(0, 33));
                2:       amt = 8'($urandom_range(0, 255));
                default: amt = 8'(32 * $urandom_range(0, 7) + $urandom_range(0, 1));
            endcase
            // the unit is drained before the random part and once in the middle of it
            queue_instr(cmd, rand_word(), rand_word(), amt, 1'($urandom_range(0, 1)),
                        rand_word(), k == 0 || k == RANDOM_ITEMS / 2);
        end
        total_items = pending_instr_q.size();

        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        while (instr_beats < total_items || expected_res_q.size() != 0)
            @(negedge clk);
        repeat (8) @(posedge clk);

        $display("Run covered %0d instructions over %0d of 16 command codes, %0d drain pauses;",
                 instr_beats, $countones(cmd_seen), drain_count);
        $display("%0d results checked field by field, %0d mismatches", res_beats, err_count);
        if (err_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

FILE: thumb_shift_logic_unit.f
rtl/tslu_pkg.sv
rtl/tslu_in_if.sv
rtl/tslu_out_if.sv
rtl/thumb_shift_logic_unit.sv
tb/sv/tb_thumb_shift_logic_unit.sv
